@@ design/bctd_pkg.sv @@
// Shared types, constants and palette functions for the BC texture block decoder.
// Used by every module of the decoder; depends on nothing else.
package bctd_pkg;

	localparam int unsigned FMT_W = 2;
	localparam logic [3:0] LAST_PIX = 4'd15;
	localparam logic [7:0] LEVEL_MAX = 8'hFF;

	typedef enum logic [FMT_W-1:0] {
		FMT_BC1 = 2'd0,
		FMT_BC3 = 2'd1,
		FMT_BC4 = 2'd2,
		FMT_BC5 = 2'd3
	} format_e;

	typedef struct packed {
		logic [63:0] color_word;
		logic [63:0] channel_word;
		logic [63:0] second_channel_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic [3:0]  pixel_index;
		logic        last_pixel;
	} out_item_t;

	typedef logic [3:0][23:0] cpal_t;
	typedef logic [7:0][7:0]  lpal_t;

	// One decoded block waiting for the pixel sequencer.
	typedef struct packed {
		format_e     mode;
		cpal_t       cpal;
		lpal_t       apal;
		lpal_t       gpal;
		logic [31:0] cidx;
		logic [47:0] aidx;
		logic [47:0] gidx;
	} pal_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Division by small constants through a reciprocal multiply. Each constant
	// is rounded up, and the error stays below the smallest fractional gap for
	// the input ranges that the palettes produce.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [22:0] p;
		p = {13'd0, x} * 23'd2731;
		return p[20:13];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd3277;
		return p[21:14];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd2341;
		return p[21:14];
	endfunction

	// Widens an RGB565 value by bit replication; channel 0 red, 1 green, 2 blue.
	function automatic logic [2:0][7:0] unpack565(input logic [15:0] c);
		logic [2:0][7:0] rgb;
		rgb[0] = {c[15:11], c[15:13]};
		rgb[1] = {c[10:5], c[10:9]};
		rgb[2] = {c[4:0], c[4:2]};
		return rgb;
	endfunction

	// Entries are {blue, green, red}; the three-color set applies only in BC1.
	function automatic cpal_t color_palette(input logic [31:0] ends, input logic allow_three);
		logic [2:0][7:0] a;
		logic [2:0][7:0] b;
		logic            four;
		logic [8:0]      sum;
		cpal_t           pal;
		a = unpack565(ends[15:0]);
		b = unpack565(ends[31:16]);
		four = !allow_three || (ends[15:0] > ends[31:16]);
		pal = '0;
		for (int ch = 0; ch < 3; ch++) begin
			pal[0][8*ch +: 8] = a[ch];
			pal[1][8*ch +: 8] = b[ch];
			sum = {1'b0, a[ch]} + {1'b0, b[ch]};
			if (four) begin
				pal[2][8*ch +: 8] = div3({1'b0, a[ch], 1'b0} + {2'b00, b[ch]});
				pal[3][8*ch +: 8] = div3({1'b0, b[ch], 1'b0} + {2'b00, a[ch]});
			end else begin
				pal[2][8*ch +: 8] = sum[8:1];
				pal[3][8*ch +: 8] = 8'h00;
			end
		end
		return pal;
	endfunction

	function automatic lpal_t level_palette(input logic [15:0] ends);
		logic [7:0]  e0;
		logic [7:0]  e1;
		logic [10:0] num;
		lpal_t       pal;
		e0 = ends[7:0];
		e1 = ends[15:8];
		pal = '0;
		pal[0] = e0;
		pal[1] = e1;
		if (e0 > e1) begin
			for (int i = 1; i <= 6; i++) begin
				num = 11'(7 - i) * {3'b000, e0} + 11'(i) * {3'b000, e1};
				pal[i + 1] = div7(num);
			end
		end else begin
			for (int i = 1; i <= 4; i++) begin
				num = 11'(5 - i) * {3'b000, e0} + 11'(i) * {3'b000, e1};
				pal[i + 1] = div5(num);
			end
			pal[6] = 8'h00;
			pal[7] = LEVEL_MAX;
		end
		return pal;
	endfunction

endpackage

@@ design/bc_texture_block_decoder.sv @@
// BC1/BC3/BC4/BC5 texture block decoder. Each accepted block yields sixteen
// 32-bit pixels in row-major order, one result transaction per cycle while
// the receiver keeps popping, paced by the pixel sequencer in the back end.
// The first pixel of a block passes through the front-end register and the
// queue into the result register when the queue and the result register are
// free. Blocks are accepted while a previous block is still being emitted;
// the input side only reports full once the decoded-block queue and the
// front-end register are both occupied. Depends on bctd_pkg.
module bc_texture_block_decoder
	import bctd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_item_t         cblock,
	input  logic             pop,
	output logic             empty,
	output out_item_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [FMT_W-1:0] cfg_data
);

	format_e     mode_q;
	logic        q_wr;
	logic        q_rd;
	pal_entry_t  q_wr_data;
	pal_entry_t  q_rd_data;
	queue_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FMT_BC1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= format_e'(cfg_data);
		end
	end

	bctd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cblock    (cblock),
		.mode      (mode_q),
		.q_full    (q_stat.full),
		.q_wr      (q_wr),
		.q_wr_data (q_wr_data)
	);

	bctd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	bctd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.q_rd      (q_rd),
		.q_rd_data (q_rd_data),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef SYNTHESIS
	// The last-pixel flag marks exactly the final position of a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last_pixel == (result.pixel_index == LAST_PIX)))
		else $error("last_pixel does not match pixel_index");

	// Within a block, pixel positions follow one another without gaps.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_pixel) ##1 !empty |->
		(result.pixel_index == 4'($past(result.pixel_index) + 4'd1)))
		else $error("pixel positions skipped or repeated");

	// The input side is only held off by a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_stat.full)
		else $error("full asserted while the queue has room");

	// The front end never writes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_wr)
		else $error("queue written while full");
`endif

endmodule

@@ design/bctd_front.sv @@
// Front end of the decoder: takes compressed blocks, builds their palettes and
// writes one decoded entry per block into the queue. Depends on bctd_pkg.
module bctd_front
	import bctd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   cblock,
	input  format_e    mode,
	input  logic       q_full,
	output logic       q_wr,
	output pal_entry_t q_wr_data
);

	logic     valid_s1;
	in_item_t item_s1;
	format_e  mode_s1;
	logic     accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	// The format is captured with the block so the entry is self-contained.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cblock;
			mode_s1 <= mode;
		end
	end

	always_comb begin
		q_wr_data.mode = mode_s1;
		q_wr_data.cpal = color_palette(item_s1.color_word[31:0], mode_s1 == FMT_BC1);
		q_wr_data.apal = level_palette(item_s1.channel_word[15:0]);
		q_wr_data.gpal = level_palette(item_s1.second_channel_word[15:0]);
		q_wr_data.cidx = item_s1.color_word[63:32];
		q_wr_data.aidx = item_s1.channel_word[63:16];
		q_wr_data.gidx = item_s1.second_channel_word[63:16];
	end

endmodule

@@ design/bctd_queue.sv @@
// Short queue of decoded blocks between the front end and the pixel sequencer.
// Depends on bctd_pkg for the entry and status types.
module bctd_queue
	import bctd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  pal_entry_t  wr_data,
	input  logic        rd,
	output pal_entry_t  rd_data,
	output queue_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pal_entry_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_data    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/bctd_back.sv @@
// Back end of the decoder: walks the sixteen pixels of the head queue entry and
// drives the result register. Depends on bctd_pkg.
module bctd_back
	import bctd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	output logic       q_rd,
	input  pal_entry_t q_rd_data,
	input  logic       pop,
	output logic       empty,
	output out_item_t  result
);

	logic       out_valid_q;
	out_item_t  result_q;
	logic [3:0] pix_q;
	logic       load;
	logic [4:0] cofs;
	logic [5:0] lofs;
	logic [1:0] ci;
	logic [2:0] ai;
	logic [2:0] gi;
	logic [31:0] px;

	assign empty  = !out_valid_q;
	assign result = result_q;
	assign load   = !q_empty && (!out_valid_q || pop);
	assign q_rd   = load && (pix_q == LAST_PIX);

	always_comb begin
		cofs = {pix_q, 1'b0};
		lofs = {pix_q, 1'b0} + {2'b00, pix_q};
		ci   = q_rd_data.cidx[cofs +: 2];
		ai   = q_rd_data.aidx[lofs +: 3];
		gi   = q_rd_data.gidx[lofs +: 3];
		unique case (q_rd_data.mode)
			FMT_BC1: px = {LEVEL_MAX, q_rd_data.cpal[ci]};
			FMT_BC3: px = {q_rd_data.apal[ai], q_rd_data.cpal[ci]};
			FMT_BC4: px = {LEVEL_MAX, 16'h0000, q_rd_data.apal[ai]};
			FMT_BC5: px = {LEVEL_MAX, 8'h00, q_rd_data.gpal[gi], q_rd_data.apal[ai]};
			default: px = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pix_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pix_q       <= pix_q + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.pixel       <= px;
			result_q.pixel_index <= pix_q;
			result_q.last_pixel  <= (pix_q == LAST_PIX);
		end
	end

endmodule

@@ tb/bc_texture_block_decoder_tb.sv @@
// Self-checking testbench for the BC1/BC3/BC4/BC5 texture block decoder.
// Predicts the sixteen pixels of every accepted block and checks them in order.
// Depends on bctd_pkg and bc_texture_block_decoder.
`timescale 1ns / 100ps

module bc_texture_block_decoder_tb;
	import bctd_pkg::*;

	typedef logic [3:0][23:0] rgb_set_t;
	typedef logic [7:0][7:0]  level_set_t;

	localparam int unsigned LONG_HOLD = 150;

	logic             clk = 1'b1;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	in_item_t         cblock = '0;
	logic             pop = 1'b0;
	logic             empty;
	out_item_t        result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [FMT_W-1:0] cfg_data = '0;

	in_item_t    blocks_to_send[$];
	out_item_t   pending_pixels[$];
	format_e     fmt_now = FMT_BC1;
	bit          in_fire = 1'b0;
	int unsigned idle_pct = 20;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_hold = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned mismatch_count = 0;

	bc_texture_block_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cblock    (cblock),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b0;
		#4 clk = 1'b1;
	end

	// Entries are {blue, green, red}, red in the low byte.
	function automatic rgb_set_t color_set(input logic [31:0] ends, input bit three_ok);
		logic [7:0]  rgb [2][3];
		logic [15:0] c;
		int unsigned x0;
		int unsigned x1;
		bit          four;
		rgb_set_t    set;
		for (int k = 0; k < 2; k++) begin
			c = ends[16*k +: 16];
			rgb[k][0] = {c[15:11], c[15:13]};
			rgb[k][1] = {c[10:5], c[10:9]};
			rgb[k][2] = {c[4:0], c[4:2]};
		end
		four = !three_ok || (ends[15:0] > ends[31:16]);
		set = '0;
		for (int ch = 0; ch < 3; ch++) begin
			x0 = rgb[0][ch];
			x1 = rgb[1][ch];
			set[0][8*ch +: 8] = rgb[0][ch];
			set[1][8*ch +: 8] = rgb[1][ch];
			if (four) begin
				set[2][8*ch +: 8] = 8'((2 * x0 + x1) / 3);
				set[3][8*ch +: 8] = 8'((2 * x1 + x0) / 3);
			end else begin
				set[2][8*ch +: 8] = 8'((x0 + x1) / 2);
			end
		end
		return set;
	endfunction

	function automatic level_set_t level_set(input logic [15:0] ends);
		int unsigned e0;
		int unsigned e1;
		level_set_t  set;
		e0 = ends[7:0];
		e1 = ends[15:8];
		set = '0;
		set[0] = ends[7:0];
		set[1] = ends[15:8];
		if (e0 > e1) begin
			for (int i = 1; i <= 6; i++)
				set[i + 1] = 8'(((7 - i) * e0 + i * e1) / 7);
		end else begin
			for (int i = 1; i <= 4; i++)
				set[i + 1] = 8'(((5 - i) * e0 + i * e1) / 5);
			set[7] = LEVEL_MAX;
		end
		return set;
	endfunction

	// Appends the sixteen pixels that one block decodes to.
	function automatic void decode_block(input in_item_t blk, input format_e fmt);
		rgb_set_t    colors;
		level_set_t  red_lv;
		level_set_t  green_lv;
		int unsigned ci;
		int unsigned ai;
		int unsigned gi;
		out_item_t   px;
		colors = color_set(blk.color_word[31:0], fmt == FMT_BC1);
		red_lv = level_set(blk.channel_word[15:0]);
		green_lv = level_set(blk.second_channel_word[15:0]);
		for (int p = 0; p < 16; p++) begin
			ci = blk.color_word[32 + 2*p +: 2];
			ai = blk.channel_word[16 + 3*p +: 3];
			gi = blk.second_channel_word[16 + 3*p +: 3];
			case (fmt)
				FMT_BC1: px.pixel = {8'hFF, colors[ci]};
				FMT_BC3: px.pixel = {red_lv[ai], colors[ci]};
				FMT_BC4: px.pixel = {8'hFF, 16'h0000, red_lv[ai]};
				default: px.pixel = {8'hFF, 8'h00, green_lv[gi], red_lv[ai]};
			endcase
			px.pixel_index = 4'(p);
			px.last_pixel = (p == 15);
			pending_pixels.push_back(px);
		end
	endfunction

	function automatic logic [47:0] ramp3(input int unsigned start);
		logic [47:0] idx;
		for (int p = 0; p < 16; p++)
			idx[3*p +: 3] = 3'(p + start);
		return idx;
	endfunction

	function automatic in_item_t pack_block(input logic [15:0] c0, input logic [15:0] c1,
			input logic [31:0] cidx, input logic [15:0] a_ends, input logic [47:0] aidx,
			input logic [15:0] g_ends, input logic [47:0] gidx);
		in_item_t blk;
		blk.color_word = {cidx, c1, c0};
		blk.channel_word = {aidx, a_ends};
		blk.second_channel_word = {gidx, g_ends};
		return blk;
	endfunction

	// Random contents, biased toward equal and extreme endpoints.
	function automatic in_item_t random_block();
		in_item_t blk;
		blk.color_word = {$urandom, $urandom};
		blk.channel_word = {$urandom, $urandom};
		blk.second_channel_word = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: blk.color_word[31:16] = blk.color_word[15:0];
			1: blk.color_word[31:0] = $urandom_range(0, 1) ? 32'hFFFF0000 : 32'h0000FFFF;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: blk.channel_word[15:8] = blk.channel_word[7:0];
			1: blk.channel_word[15:0] = $urandom_range(0, 1) ? 16'hFF00 : 16'h00FF;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: blk.second_channel_word[15:8] = blk.second_channel_word[7:0];
			1: blk.second_channel_word[15:0] = $urandom_range(0, 1) ? 16'hFF00 : 16'h00FF;
			default: ;
		endcase
		return blk;
	endfunction

	// Block sender: holds each transaction until it is taken, with random gaps between.
	always @(negedge clk) begin : block_sender
		bit taken;
		taken = in_fire;
		if (taken)
			void'(blocks_to_send.pop_front());
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !taken) begin
			// The current transaction stays on the bus.
		end else if (tx_gap > 0) begin
			tx_gap = tx_gap - 1;
			push <= 1'b0;
		end else if (blocks_to_send.size() == 0) begin
			push <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			tx_gap = $urandom_range(0, 4);
			push <= 1'b0;
		end else begin
			push <= 1'b1;
			cblock <= blocks_to_send[0];
		end
	end

	// Pixel receiver: random stall bursts, plus a long hold when one is requested.
	always @(negedge clk) begin : pixel_receiver
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			rx_hold = LONG_HOLD;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap = rx_gap - 1;
			pop <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			rx_gap = $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin : pixel_checker
		out_item_t want;
		in_fire = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				fmt_now = format_e'(cfg_data);
			if (push && !full) begin
				in_fire = 1'b1;
				decode_block(cblock, fmt_now);
			end
			if (pop && !empty) begin
				if (pending_pixels.size() == 0) begin
					mismatch_count++;
					$error("unexpected pixel transaction: pixel %h index %0d",
						result.pixel, result.pixel_index);
				end else begin
					want = pending_pixels.pop_front();
					if (want !== result)
						mismatch_count++;
					if (want.pixel !== result.pixel)
						$error("pixel: expected %h, actual %h", want.pixel, result.pixel);
					if (want.pixel_index !== result.pixel_index)
						$error("pixel_index: expected %0d, actual %0d",
							want.pixel_index, result.pixel_index);
					if (want.last_pixel !== result.last_pixel)
						$error("last_pixel: expected %0b, actual %0b",
							want.last_pixel, result.last_pixel);
				end
			end
		end
	end

	task automatic write_format(input format_e fmt);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= fmt;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (blocks_to_send.size() != 0 || push || pending_pixels.size() != 0);
	endtask

	initial begin : stimulus
		format_e fmt;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed blocks under every format: extremes, both palette orders, equal endpoints.
		for (int f = 0; f < 4; f++) begin
			write_format(format_e'(f));
			blocks_to_send.push_back('0);
			blocks_to_send.push_back('1);
			blocks_to_send.push_back(pack_block(16'hF81F, 16'h07E0, 32'hE4E4E4E4,
				16'h10F0, ramp3(0), 16'h00FF, ramp3(3)));
			blocks_to_send.push_back(pack_block(16'h001F, 16'hFFE0, 32'h1B1B1B1B,
				16'hFA05, ramp3(5), 16'hFF00, ramp3(1)));
			blocks_to_send.push_back(pack_block(16'h7BEF, 16'h7BEF, $urandom,
				16'h8080, ramp3(2), 16'h3333, ramp3(6)));
			wait_drained();
		end

		for (int ph = 0; ph < 10; ph++) begin
			fmt = format_e'($urandom_range(0, 3));
			write_format(fmt);
			// Phase 3 runs without gaps mid-run; the last two close the run without gaps.
			if (ph == 3 || ph >= 8)
				idle_pct = 0;
			else
				idle_pct = $urandom_range(5, 40);
			if (ph == 1)
				hold_requests++;
			repeat (25) blocks_to_send.push_back(random_block());
			// In phase 4 the stimulus waits here until every pixel so far has come out.
			if (ph == 4)
				wait_drained();
			repeat (25) blocks_to_send.push_back(random_block());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
